// ===== rtl/core/altb_pkg.sv =====
package altb_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam int LenW = 24;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               final_point;
  } in_req_t;

  typedef struct packed {
    logic [5:0]  entry_index;
    logic [16:0] param_fraction;
    logic [16:0] arc_fraction;
    logic        last_entry;
  } out_req_t;

endpackage

// ===== rtl/core/altb_ram.sv =====
module altb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/arc_length_table_builder.sv =====
// Arc-length table builder. Points arrive as signed Q8.8 x, y, z; each point
// after the first adds floor(sqrt(dx^2+dy^2+dz^2)) to a saturating 24-bit
// running length stored in a 64-entry table RAM. Each point's length comes from
// a bit-pair square root (17 iterations). A final point then emits one request
// per stored point, each computed by two 17-bit restoring divisions (parameter
// and arc fraction) sharing one divider.
module arc_length_table_builder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  altb_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output altb_pkg::out_req_t out_data
);
  import altb_pkg::*;

  localparam logic [3:0] StIdle = 4'd0, StSq = 4'd1, StSqrt = 4'd2, StWr = 4'd3,
                         StRdT = 4'd4, StRdTw = 4'd5, StRd = 4'd6, StRdw = 4'd7,
                         StDivP = 4'd8, StDivA = 4'd9, StOut = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic signed [15:0] px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic [LenW-1:0] run_r, run_nxt, total_r, total_nxt;
  in_req_t req_r, req_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [33:0] sq_r, sq_nxt;
  logic [16:0] root_r, root_nxt;
  logic [4:0] step_r, step_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [40:0] num_r, num_nxt;
  logic [LenW-1:0] rem_r, rem_nxt;
  logic [16:0] quo_r, quo_nxt, pf_r, pf_nxt;
  logic out_valid_r, out_valid_nxt;
  out_req_t out_r, out_nxt;

  logic wr_en;
  logic [IdxW-1:0] rd_addr;
  logic [LenW-1:0] rd_data;
  logic signed [16:0] diff;
  logic [16:0] mag;
  logic [33:0] prod;
  logic [35:0] trial;
  logic [LenW:0] rem_sh;
  logic [LenW-1:0] divisor;
  logic [LenW:0] run_sum;

  altb_ram #(.Width(LenW), .Depth(MaxPoints)) u_ram (
    .clk, .wr_en, .wr_addr(count_r[IdxW-1:0]), .wr_data(run_nxt),
    .rd_addr, .rd_data
  );

  assign in_stall = (state_r != StIdle);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; px_nxt = px_r; py_nxt = py_r;
    pz_nxt = pz_r; run_nxt = run_r; total_nxt = total_r; req_nxt = req_r;
    axis_nxt = axis_r; sq_nxt = sq_r; root_nxt = root_r; step_nxt = step_r;
    idx_nxt = idx_r; num_nxt = num_r; rem_nxt = rem_r; quo_nxt = quo_r;
    pf_nxt = pf_r; out_valid_nxt = out_valid_r; out_nxt = out_r;
    wr_en = 1'b0; rd_addr = idx_r;
    diff = '0; mag = '0; prod = '0; trial = '0; divisor = '0;
    run_sum = {1'b0, run_r} + {7'd0, root_r};
    rem_sh = {rem_r, num_r[40]};
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      StIdle: begin
        if (in_valid) begin
          req_nxt = in_data;
          if (count_r == CntW'(MaxPoints)) begin
            if (in_data.final_point) state_nxt = StRdT;
          end else if (count_r == '0) begin
            run_nxt = '0; state_nxt = StWr;
          end else begin
            sq_nxt = '0; axis_nxt = 2'd0; state_nxt = StSq;
          end
        end
      end
      StSq: begin
        case (axis_r)
          2'd0: diff = 17'(req_r.point_x) - 17'(px_r);
          2'd1: diff = 17'(req_r.point_y) - 17'(py_r);
          default: diff = 17'(req_r.point_z) - 17'(pz_r);
        endcase
        mag = diff[16] ? 17'(-diff) : 17'(diff);
        prod = mag * mag;
        sq_nxt = sq_r + prod;
        if (axis_r == 2'd2) begin
          root_nxt = '0; num_nxt = '0; step_nxt = 5'd17; state_nxt = StSqrt;
        end
        axis_nxt = axis_r + 2'd1;
      end
      StSqrt: begin
        // One result bit per step: shift remainder by two bits of the radicand.
        trial = {num_r[33:0], sq_r[33:32]} - 36'({root_r, 2'b01});
        if (!trial[35]) begin
          num_nxt = {5'd0, trial};
          root_nxt = {root_r[15:0], 1'b1};
        end else begin
          num_nxt = {5'd0, num_r[33:0], sq_r[33:32]};
          root_nxt = {root_r[15:0], 1'b0};
        end
        sq_nxt = {sq_r[31:0], 2'b00};
        step_nxt = step_r - 5'd1;
        if (step_r == 5'd1) state_nxt = StWr;
      end
      StWr: begin
        if (count_r != '0) run_nxt = run_sum[LenW] ? '1 : run_sum[LenW-1:0];
        wr_en = 1'b1;
        px_nxt = req_r.point_x; py_nxt = req_r.point_y; pz_nxt = req_r.point_z;
        count_nxt = count_r + 1'b1;
        state_nxt = req_r.final_point ? StRdT : StIdle;
      end
      StRdT: begin
        rd_addr = IdxW'(count_r - 1'b1); state_nxt = StRdTw;
      end
      StRdTw: begin
        total_nxt = rd_data; idx_nxt = '0; state_nxt = StRd;
      end
      StRd: begin
        rd_addr = idx_r; state_nxt = StRdw;
      end
      StRdw: begin
        num_nxt = {idx_r[0], 40'd0}; rem_nxt = LenW'(idx_r >> 1); quo_nxt = '0;
        step_nxt = 5'd17; run_nxt = rd_data; state_nxt = StDivP;
        if (count_r == CntW'(1)) begin
          pf_nxt = '0; step_nxt = 5'd1; num_nxt = '0; rem_nxt = '0;
        end
      end
      StDivP, StDivA: begin
        divisor = (state_r == StDivP) ? LenW'(count_r - 1'b1) : total_r;
        if (rem_sh >= {1'b0, divisor}) begin
          rem_nxt = LenW'(rem_sh - {1'b0, divisor}); quo_nxt = {quo_r[15:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[LenW-1:0]; quo_nxt = {quo_r[15:0], 1'b0};
        end
        num_nxt = {num_r[39:0], 1'b0};
        step_nxt = step_r - 5'd1;
        if (step_r == 5'd1) begin
          if (state_r == StDivP) begin
            pf_nxt = (count_r == CntW'(1)) ? 17'd0 : quo_nxt;
            num_nxt = {run_r[0], 40'd0}; rem_nxt = {1'b0, run_r[LenW-1:1]};
            quo_nxt = '0;
            step_nxt = 5'd17;
            state_nxt = StDivA;
          end else begin
            state_nxt = StOut;
          end
        end
      end
      StOut: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt.entry_index = idx_r;
          out_nxt.param_fraction = pf_r;
          out_nxt.arc_fraction = (total_r == '0) ? 17'd0 : quo_r;
          out_nxt.last_entry = (CntW'(idx_r) == count_r - 1'b1);
          if (CntW'(idx_r) == count_r - 1'b1) begin
            count_nxt = '0; px_nxt = '0; py_nxt = '0; pz_nxt = '0; run_nxt = '0;
            state_nxt = StIdle;
          end else begin
            idx_nxt = idx_r + 1'b1; state_nxt = StRd;
          end
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle; count_r <= '0; px_r <= '0; py_r <= '0; pz_r <= '0;
      run_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; px_r <= px_nxt; py_r <= py_nxt;
      pz_r <= pz_nxt; run_r <= run_nxt; out_valid_r <= out_valid_nxt;
    end
    total_r <= total_nxt; req_r <= req_nxt; axis_r <= axis_nxt; sq_r <= sq_nxt;
    root_r <= root_nxt; step_r <= step_nxt; idx_r <= idx_nxt; num_r <= num_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; pf_r <= pf_nxt; out_r <= out_nxt;
  end

endmodule

// ===== rtl/core/altb_checker.sv =====
module altb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input altb_pkg::out_req_t out_data
);
  import altb_pkg::*;

  // A stalled input request stays offered.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("in held");

  // A stalled request must hold.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");

  // Fractions never exceed one.
  a_pf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.param_fraction <= 17'd65536) else $error("pf range");

  a_af: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.arc_fraction <= 17'd65536) else $error("af range");

  // The last entry always reports a parameter of one unless it is the only entry.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_entry && out_data.entry_index != 6'd0
      |-> out_data.param_fraction == 17'd65536) else $error("last pf");

endmodule

bind arc_length_table_builder altb_checker u_altb_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
